FILE: hdl/mandelbrot_escape_time_defines.svh
// -----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Property wrappers clocked on clk_i, disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication
`define MBET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mbet_pkg.sv
// -----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Widths, reset values, sequencer states, unit interface types and saturation.
// -----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

  localparam int unsigned IdxW    = 11;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StepW   = 24;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracW   = 26;
  localparam int unsigned ProdW   = 2 * ValW;
  localparam int unsigned SatW    = ProdW + 2;

  localparam int unsigned ImageSideMax = 2048;

  localparam logic signed [ValW-1:0]   RealStartRst = -32'sd134217728;
  localparam logic        [StepW-1:0]  RealStepRst  = 24'd86333;
  localparam logic signed [ValW-1:0]   ImagStartRst = -32'sd75161928;
  localparam logic        [StepW-1:0]  ImagStepRst  = 24'd139189;
  localparam logic        [CountW-1:0] IterLimitRst = 16'd5000;

  localparam logic [ProdW:0] EscapeLimit = (ProdW + 1)'(1) << (2 * FracW + 2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_REAL_START = 3'd0,
    REG_REAL_STEP  = 3'd1,
    REG_IMAG_START = 3'd2,
    REG_IMAG_STEP  = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAP  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic                   mul_en;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
    logic signed [ValW-1:0] cr;
    logic signed [ValW-1:0] ci;
  } core_req_t;

  typedef struct packed {
    logic                   escape;
    logic signed [ValW-1:0] nx;
    logic signed [ValW-1:0] ny;
  } core_rsp_t;

  function automatic logic signed [ValW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(64'sd2147483647);
    lo = SatW'(-64'sd2147483648);
    if (v > hi) begin
      return hi[ValW-1:0];
    end else if (v < lo) begin
      return lo[ValW-1:0];
    end else begin
      return v[ValW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mbet_core.sv
// -----------------------------------------------------------------------------
// Mandelbrot iteration unit
// Registered products x*x, y*y, x*y, then escape test and saturated update.
// -----------------------------------------------------------------------------
`default_nettype none

module mbet_core (
  input  logic              clk_i,
  input  mbet_pkg::core_req_t req_i,
  output mbet_pkg::core_rsp_t rsp_o
);
  import mbet_pkg::*;

  logic signed [ProdW-1:0] pxx_q, pyy_q, pxy_q;
  logic        [ProdW:0]   mag_sum;
  logic signed [ProdW:0]   diff;
  logic signed [ProdW:0]   diff_sh;
  logic signed [ProdW-1:0] pxy_sh;
  logic signed [SatW-1:0]  cr_ext, ci_ext;

  always_ff @(posedge clk_i) begin
    if (req_i.mul_en) begin
      pxx_q <= req_i.x * req_i.x;
      pyy_q <= req_i.y * req_i.y;
      pxy_q <= req_i.x * req_i.y;
    end
  end

  always_comb begin
    mag_sum = {1'b0, pxx_q} + {1'b0, pyy_q};
    diff    = {pxx_q[ProdW-1], pxx_q} - {pyy_q[ProdW-1], pyy_q};
    diff_sh = diff >>> FracW;
    pxy_sh  = pxy_q >>> (FracW - 1);
    cr_ext  = {{(SatW - ValW){req_i.cr[ValW-1]}}, req_i.cr};
    ci_ext  = {{(SatW - ValW){req_i.ci[ValW-1]}}, req_i.ci};

    rsp_o.escape = mag_sum > EscapeLimit;
    rsp_o.nx     = sat32({diff_sh[ProdW], diff_sh} + cr_ext);
    rsp_o.ny     = sat32({{2{pxy_sh[ProdW-1]}}, pxy_sh} + ci_ext);
  end

endmodule

`default_nettype wire

FILE: hdl/mandelbrot_escape_time.sv
// -----------------------------------------------------------------------------
// Mandelbrot escape-time block
// Maps a pixel to c, iterates z = z*z + c and returns the iteration count.
// -----------------------------------------------------------------------------
// Input channel: column_i/row_i with in_valid_i; in_stall_o is high while an
// item is in work, so one pixel is processed at a time.
// Output channel: out_column_o/out_row_o/out_iteration_count_o with
// out_valid_o; the word holds while out_stall_i is high.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, unknown indexes are dropped.
// Each iteration uses the shared multiply unit: ST_MUL registers the three
// products, then ST_UPD does the escape test and update. A new pixel is
// not accepted until the previous one has left ST_FIN for ST_IDLE.
// A finished result waits in the output register; the next pixel may be
// accepted meanwhile, and its result waits until that register is free.
// Reset: sequencer idle, no result pending, registers back to the default
// window of 2.47 by 2.24 units over 1920x1080 pixels, limit 5000.
// -----------------------------------------------------------------------------
`default_nettype none
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mbet_pkg::IdxW-1:0]       column_i,
  input  logic [mbet_pkg::IdxW-1:0]       row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mbet_pkg::IdxW-1:0]       out_column_o,
  output logic [mbet_pkg::IdxW-1:0]       out_row_o,
  output logic [mbet_pkg::CountW-1:0]     out_iteration_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbet_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mbet_pkg::ValW-1:0]       cfg_data_i
);
  import mbet_pkg::*;

  state_e                 state_q, state_d;
  logic signed [ValW-1:0] real_start_q, imag_start_q;
  logic [StepW-1:0]       real_step_q, imag_step_q;
  logic [CountW-1:0]      limit_q;

  logic [IdxW-1:0]        col_q, row_q;
  logic signed [ValW-1:0] cr_q, ci_q, x_q, y_q;
  logic [CountW-1:0]      count_q;

  logic                   out_valid_q;
  logic [IdxW-1:0]        out_col_q, out_row_q;
  logic [CountW-1:0]      out_count_q;

  logic                   in_acc, out_free;
  logic [IdxW-1:0]        col_cl, row_cl;
  logic [IdxW+StepW-1:0]  col_prod, row_prod;
  logic signed [SatW-1:0] cr_sum, ci_sum;

  core_req_t              core_req;
  core_rsp_t              core_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // clamp to the image side, then map
  always_comb begin
    col_cl   = ({1'b0, col_q} >= (IdxW + 1)'(ImageSideMax)) ? IdxW'(ImageSideMax - 1) : col_q;
    row_cl   = ({1'b0, row_q} >= (IdxW + 1)'(ImageSideMax)) ? IdxW'(ImageSideMax - 1) : row_q;
    col_prod = (IdxW + StepW)'(col_cl) * (IdxW + StepW)'(real_step_q);
    row_prod = (IdxW + StepW)'(row_cl) * (IdxW + StepW)'(imag_step_q);
    cr_sum   = {{(SatW - ValW){real_start_q[ValW-1]}}, real_start_q}
             + SatW'(col_prod);
    ci_sum   = {{(SatW - ValW){imag_start_q[ValW-1]}}, imag_start_q}
             + SatW'(row_prod);
  end

  always_comb begin
    core_req.mul_en = (state_q == ST_MUL);
    core_req.x      = x_q;
    core_req.y      = y_q;
    core_req.cr     = cr_q;
    core_req.ci     = ci_q;
  end

  mbet_core u_core (
    .clk_i (clk_i),
    .req_i (core_req),
    .rsp_o (core_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: state_d = ST_MUL;
      ST_MUL: begin
        state_d = (count_q < limit_q) ? ST_UPD : ST_FIN;
      end
      ST_UPD: begin
        state_d = core_rsp.escape ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      real_start_q <= RealStartRst;
      real_step_q  <= RealStepRst;
      imag_start_q <= ImagStartRst;
      imag_step_q  <= ImagStepRst;
      limit_q      <= IterLimitRst;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_REAL_START: real_start_q <= cfg_data_i;
          REG_REAL_STEP:  real_step_q  <= cfg_data_i[StepW-1:0];
          REG_IMAG_START: imag_start_q <= cfg_data_i;
          REG_IMAG_STEP:  imag_step_q  <= cfg_data_i[StepW-1:0];
          REG_ITER_LIMIT: limit_q      <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (state_q == ST_MAP) begin
      cr_q    <= sat32(cr_sum);
      ci_q    <= sat32(ci_sum);
      x_q     <= '0;
      y_q     <= '0;
      count_q <= '0;
    end
    if (state_q == ST_UPD && !core_rsp.escape) begin
      x_q     <= core_rsp.nx;
      y_q     <= core_rsp.ny;
      count_q <= count_q + CountW'(1);
    end
    if (state_q == ST_FIN && out_free) begin
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_column_o          = out_col_q;
  assign out_row_o             = out_row_q;
  assign out_iteration_count_o = out_count_q;

  `MBET_ASSERT_NEXT(a_accept_maps, in_acc, state_q == ST_MAP, "accepted word not mapped")
  `MBET_ASSERT_IMPL(a_result_src, $rose(out_valid_o), $past(state_q) == ST_FIN,
                    "result raised outside finish")
  `MBET_ASSERT_NEXT(a_fin_hold, state_q == ST_FIN && out_valid_o && out_stall_i,
                    state_q == ST_FIN, "finished result dropped under stall")

endmodule

`default_nettype wire
